/* design/tcw_pkg.sv */
`timescale 1ns / 1ps

package tcw_pkg;

  // screen geometry defaults
  localparam int unsigned COLUMNS_DEF = 80;
  localparam int unsigned ROWS_DEF    = 25;

  // command codes
  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // control bytes
  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;

  localparam logic [7:0]  COLOR_RESET = 8'd23;
  localparam logic [15:0] CELL_RESET  = {COLOR_RESET, CH_SPACE};

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  ch;
    logic [10:0] cell_index;
  } tcw_in_t;

  typedef struct packed {
    logic [15:0] cell_value;
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
  } tcw_out_t;

endpackage

/* design/tcw_ram.sv */
`timescale 1ns / 1ps

module tcw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/text_console_cell_writer.sv */
`timescale 1ns / 1ps

// channel | dir | handshake             | payload
// in      | in  | in_valid_i/in_stall_o   | tcw_in_t  (cmd, ch, cell_index)
// out     | out | out_valid_o/out_stall_i | tcw_out_t (cell_value, cursor_col, cursor_row)
// cfg     | in  | cfg_we_i                | text_color byte
//
// a put beat that needs no scroll finishes in the accept cycle; a read goes
// through the registered ram read. clear blanks all cells; a scroll moves rows
// up and blanks the last row, both bound by the single ram write port sweeping
// the screen. after reset a clearing pass fills all COLUMNS*ROWS cells; no beat
// is taken meanwhile. input stalls while busy or while the result beat is held.

module text_console_cell_writer #(
  parameter int unsigned COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  tcw_pkg::tcw_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output tcw_pkg::tcw_out_t out_data_o,
  input  logic             cfg_we_i,
  input  logic [7:0]       cfg_data_i
);

  import tcw_pkg::*;

  localparam int unsigned CELLS = COLUMNS * ROWS;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned CW    = $clog2(COLUMNS + 8);
  localparam int unsigned RW    = $clog2(ROWS);

  typedef enum logic [2:0] {S_IDLE, S_BLANK, S_SCROLL, S_SCWR, S_DONE} state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [AW-1:0] base_q, base_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic [15:0]   fill_q, fill_d;
  logic          init_q, init_d;
  logic          rd_q, rd_d;
  logic [7:0]    color_q;
  tcw_out_t      out_q, out_d;
  logic          out_valid_q, out_valid_d;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [15:0]   ram_wdata, ram_rdata;

  logic          out_free, accept, load_out;
  logic [15:0]   load_val;
  logic [15:0]   blank;

  // put decode
  logic          put_we;
  logic [15:0]   put_wdata;
  logic [CW-1:0] put_col;
  logic          put_adv;
  logic [CW-1:0] col_inc, tab_sum;

  logic [CW+6:0] col_x;
  logic [RW+4:0] row_x;

  tcw_ram #(.WIDTH(16), .DEPTH(CELLS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign blank      = {color_q, CH_SPACE};
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == S_IDLE) && out_free);
  assign accept     = in_valid_i && !in_stall_o;
  assign col_inc    = col_q + CW'(1);
  assign tab_sum    = col_q + CW'(8);

  // cursor motion and cell write for one put byte
  always_comb begin
    put_we    = 1'b0;
    put_wdata = {color_q, in_data_i.ch};
    put_col   = col_q;
    put_adv   = 1'b0;
    unique case (in_data_i.ch)
      CH_LF: begin
        put_adv = 1'b1;
      end
      CH_BS: begin
        if (col_q != '0) begin
          put_we    = 1'b1;
          put_wdata = blank;
          put_col   = col_q - CW'(1);
        end
      end
      CH_CR: begin
        put_col = '0;
      end
      CH_TAB: begin
        put_col = {tab_sum[CW-1:3], 3'b000};
        put_adv = ({tab_sum[CW-1:3], 3'b000} >= CW'(COLUMNS));
      end
      default: begin
        put_we  = 1'b1;
        put_col = col_inc;
        put_adv = (col_inc == CW'(COLUMNS));
      end
    endcase
  end

  // sequencer and ram port control
  always_comb begin
    state_d   = state_q;
    col_d     = col_q;
    row_d     = row_q;
    base_d    = base_q;
    ptr_d     = ptr_q;
    fill_d    = fill_q;
    init_d    = init_q;
    rd_d      = rd_q;
    ram_we    = 1'b0;
    ram_waddr = base_q + AW'(col_q);
    ram_wdata = put_wdata;
    ram_re    = 1'b0;
    ram_raddr = AW'(in_data_i.cell_index);
    load_out  = 1'b0;
    load_val  = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (in_data_i.cmd)
            CMD_PUT: begin
              ram_we = put_we;
              col_d  = put_col;
              if (put_adv) begin
                col_d = '0;
                if (row_q == RW'(ROWS - 1)) begin
                  ptr_d   = '0;
                  fill_d  = blank;
                  rd_d    = 1'b0;
                  state_d = S_SCROLL;
                end else begin
                  row_d    = row_q + RW'(1);
                  base_d   = base_q + AW'(COLUMNS);
                  load_out = 1'b1;
                end
              end else begin
                load_out = 1'b1;
              end
            end
            CMD_READ: begin
              if (32'(in_data_i.cell_index) < 32'(CELLS)) begin
                ram_re  = 1'b1;
                rd_d    = 1'b1;
                state_d = S_DONE;
              end else begin
                load_out = 1'b1;
              end
            end
            CMD_CLEAR: begin
              col_d   = '0;
              row_d   = '0;
              base_d  = '0;
              ptr_d   = '0;
              fill_d  = blank;
              rd_d    = 1'b0;
              state_d = S_BLANK;
            end
            default: begin
              load_out = 1'b1;
            end
          endcase
        end
      end
      S_SCROLL: begin
        // read one row below, write the cell fetched last cycle
        ram_re    = 1'b1;
        ram_raddr = ptr_q + AW'(COLUMNS);
        ram_we    = (ptr_q != '0);
        ram_waddr = ptr_q - AW'(1);
        ram_wdata = ram_rdata;
        ptr_d     = ptr_q + AW'(1);
        if (ptr_q == AW'(CELLS - COLUMNS - 1)) begin
          state_d = S_SCWR;
        end
      end
      S_SCWR: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_q - AW'(1);
        ram_wdata = ram_rdata;
        state_d   = S_BLANK;
      end
      S_BLANK: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_q;
        ram_wdata = fill_q;
        ptr_d     = ptr_q + AW'(1);
        if (ptr_q == AW'(CELLS - 1)) begin
          init_d  = 1'b0;
          state_d = init_q ? S_IDLE : S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          load_out = 1'b1;
          load_val = rd_q ? ram_rdata : '0;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // result beat from the updated cursor
  always_comb begin
    col_x              = (CW + 7)'(col_d);
    row_x              = (RW + 5)'(row_d);
    out_d              = out_q;
    out_valid_d        = out_valid_q && out_stall_i;
    if (load_out) begin
      out_d.cell_value = load_val;
      out_d.cursor_col = col_x[6:0];
      out_d.cursor_row = row_x[4:0];
      out_valid_d      = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_BLANK;
      col_q       <= '0;
      row_q       <= '0;
      base_q      <= '0;
      ptr_q       <= '0;
      fill_q      <= CELL_RESET;
      init_q      <= 1'b1;
      rd_q        <= 1'b0;
      color_q     <= COLOR_RESET;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      row_q       <= row_d;
      base_q      <= base_d;
      ptr_q       <= ptr_d;
      fill_q      <= fill_d;
      init_q      <= init_d;
      rd_q        <= rd_d;
      out_q       <= out_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        color_q <= cfg_data_i;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
